// ===== design/lca_pkg.sv =====
// ----------------------------------------------------------------------------
// lca_pkg
// Shared types and constants for the binary-lifting lowest common ancestor
// engine: item kinds, result status codes, controller states, datapath commands and status.
// ----------------------------------------------------------------------------
package lca_pkg;

  // fixed field widths
  localparam int NODE_W  = 10;
  localparam int ENTRY_W = NODE_W + 1;   // stored entry is node+1, zero means none
  localparam int DEPTH_W = 10;
  localparam logic [DEPTH_W-1:0] DEPTH_SAT = '1;

  // item kinds
  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_LCA  = 2'd1,
    KIND_KTH  = 2'd2,
    KIND_BAD  = 2'd3
  } kind_t;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_PAST_ROOT = 2'd1,
    STAT_BAD       = 2'd2
  } status_t;

  // source of the answer node on completion
  typedef enum logic [1:0] {
    RES_B,
    RES_U,
    RES_PARENT
  } res_sel_t;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_LP_RD,
    OP_LD_WR0,
    OP_LD_RD,
    OP_LD_WR,
    OP_KD_RD,
    OP_DA_RD,
    OP_DB_RD,
    OP_LEVEL,
    OP_CL_RD,
    OP_CL_SKIP,
    OP_CL_STEP,
    OP_J_INIT,
    OP_J_RU,
    OP_J_RV,
    OP_J_CMP,
    OP_P_RD
  } dp_op_t;

  // controller states
  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_LD_WR0,
    S_LD_RD,
    S_LD_WR,
    S_KD_CHK,
    S_DB,
    S_LV,
    S_LV_CHK,
    S_CL_RD,
    S_CL_WT,
    S_CL_END,
    S_J_RU,
    S_J_RV,
    S_J_CMP,
    S_P_RD,
    S_P_WT
  } state_t;

  // command from controller to datapath
  typedef struct packed {
    dp_op_t   op;
    logic     done;
    status_t  code;
    res_sel_t res;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  bad;
    logic  k_high;
    logic  k_gt;
    logic  k_bit;
    logic  lvl_last;
    logic  lvl_zero;
    logic  one_level;
    logic  e_zero;
    logic  uv_eq;
  } dp_stat_t;

endpackage

// ===== design/lca_ram.sv =====
// ----------------------------------------------------------------------------
// lca_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/lca_ctrl.sv =====
// ----------------------------------------------------------------------------
// lca_ctrl
// Sequencer for load, k-th ancestor and common ancestor items. Issues one
// datapath command per cycle and decides on the datapath status flags.
// ----------------------------------------------------------------------------
module lca_ctrl
  import lca_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat,
  output cmd_t     cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (start) state_nxt = S_CHECK;
      S_CHECK: begin
        if (stat.bad) begin
          state_nxt = S_IDLE;
        end else begin
          unique case (stat.kind)
            KIND_LOAD: state_nxt = S_LD_WR0;
            KIND_LCA:  state_nxt = S_DB;
            KIND_KTH:  state_nxt = S_KD_CHK;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_LD_WR0: state_nxt = stat.one_level ? S_IDLE : S_LD_RD;
      S_LD_RD:  state_nxt = S_LD_WR;
      S_LD_WR:  state_nxt = stat.lvl_last ? S_IDLE : S_LD_RD;
      S_KD_CHK: state_nxt = (stat.k_gt || stat.k_high) ? S_IDLE : S_CL_RD;
      S_DB:     state_nxt = S_LV;
      S_LV:     state_nxt = S_LV_CHK;
      S_LV_CHK: state_nxt = stat.k_high ? S_IDLE : S_CL_RD;
      S_CL_RD: begin
        if (stat.k_bit) begin
          state_nxt = S_CL_WT;
        end else begin
          state_nxt = stat.lvl_last ? S_CL_END : S_CL_RD;
        end
      end
      S_CL_WT: begin
        if (stat.e_zero) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = stat.lvl_last ? S_CL_END : S_CL_RD;
        end
      end
      S_CL_END: begin
        state_nxt = (stat.kind == KIND_KTH || stat.uv_eq) ? S_IDLE : S_J_RU;
      end
      S_J_RU:   state_nxt = S_J_RV;
      S_J_RV:   state_nxt = S_J_CMP;
      S_J_CMP:  state_nxt = stat.lvl_zero ? S_P_RD : S_J_RU;
      S_P_RD:   state_nxt = S_P_WT;
      S_P_WT:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    cmd.op   = OP_NONE;
    cmd.code = STAT_OK;
    cmd.res  = RES_B;
    unique case (state_r)
      S_IDLE:   if (start) cmd.op = OP_CAPTURE;
      S_CHECK: begin
        if (stat.bad) begin
          cmd.done = 1'b1;
          cmd.code = STAT_BAD;
        end else begin
          unique case (stat.kind)
            KIND_LOAD: cmd.op = OP_LP_RD;
            KIND_LCA:  cmd.op = OP_DA_RD;
            KIND_KTH:  cmd.op = OP_KD_RD;
            default: begin
              cmd.done = 1'b1;
              cmd.code = STAT_BAD;
            end
          endcase
        end
      end
      S_LD_WR0: begin
        cmd.op   = OP_LD_WR0;
        cmd.done = stat.one_level;
        cmd.res  = RES_B;
      end
      S_LD_RD:  cmd.op = OP_LD_RD;
      S_LD_WR: begin
        cmd.op   = OP_LD_WR;
        cmd.done = stat.lvl_last;
        cmd.res  = RES_B;
      end
      S_KD_CHK: begin
        if (stat.k_gt || stat.k_high) begin
          cmd.done = 1'b1;
          cmd.code = STAT_PAST_ROOT;
        end
      end
      S_DB:     cmd.op = OP_DB_RD;
      S_LV:     cmd.op = OP_LEVEL;
      S_LV_CHK: begin
        if (stat.k_high) begin
          cmd.done = 1'b1;
          cmd.code = STAT_PAST_ROOT;
        end
      end
      S_CL_RD:  cmd.op = stat.k_bit ? OP_CL_RD : OP_CL_SKIP;
      S_CL_WT: begin
        if (stat.e_zero) begin
          cmd.done = 1'b1;
          cmd.code = STAT_PAST_ROOT;
        end else begin
          cmd.op = OP_CL_STEP;
        end
      end
      S_CL_END: begin
        if (stat.kind == KIND_KTH || stat.uv_eq) begin
          cmd.done = 1'b1;
          cmd.res  = RES_U;
        end else begin
          cmd.op = OP_J_INIT;
        end
      end
      S_J_RU:   cmd.op = OP_J_RU;
      S_J_RV:   cmd.op = OP_J_RV;
      S_J_CMP:  cmd.op = OP_J_CMP;
      S_P_RD:   cmd.op = OP_P_RD;
      S_P_WT: begin
        cmd.done = 1'b1;
        cmd.code = stat.e_zero ? STAT_PAST_ROOT : STAT_OK;
        cmd.res  = RES_PARENT;
      end
      default:  cmd.op = OP_NONE;
    endcase
  end

endmodule

// ===== design/lca_dpath.sv =====
// ----------------------------------------------------------------------------
// lca_dpath
// Datapath: item registers, node walkers u and v, level counter, the
// ancestor and depth memories and the result register.
// ----------------------------------------------------------------------------
module lca_dpath
  import lca_pkg::*;
#(
  parameter int NODES  = 1024,
  parameter int LEVELS = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output dp_stat_t          stat,
  input  logic [1:0]        in_kind,
  input  logic [NODE_W-1:0] in_node_a,
  input  logic [NODE_W-1:0] in_node_b,
  input  logic [NODE_W-1:0] in_distance,
  output logic              out_valid,
  output logic [NODE_W-1:0] out_answer_node,
  output logic [1:0]        out_status
);

  localparam int ANC_DEPTH = NODES * LEVELS;
  localparam int AAW       = $clog2(ANC_DEPTH);
  localparam int DAW       = $clog2(NODES);
  localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  // item and walker registers
  kind_t              kind_r;
  logic [NODE_W-1:0]  a_r, b_r, k_r, u_r, v_r;
  logic [LVL_W-1:0]   lvl_r;
  logic [ENTRY_W-1:0] e_r;
  logic [DEPTH_W-1:0] da_r;
  logic               anc_zero_r, dep_zero_r;

  // result registers
  logic               out_valid_r;
  logic [NODE_W-1:0]  out_answer_r;
  logic [1:0]         out_status_r;

  // memory ports
  logic               anc_we;
  logic [AAW-1:0]     anc_waddr, anc_raddr;
  logic [ENTRY_W-1:0] anc_wdata, anc_rdata, anc_q;
  logic [DAW-1:0]     dep_waddr, dep_raddr;
  logic [DEPTH_W-1:0] dep_wdata, dep_rdata, dep_q;

  logic [NODE_W-1:0]  rd_node, wr_node, dep_rnode;
  logic [LVL_W-1:0]   rd_lvl, wr_lvl;
  logic [31:0]        rd_prod, wr_prod, dep_rext, dep_wext;
  logic [ENTRY_W-1:0] ld_val, b_entry;
  logic [NODE_W-1:0]  parent_node;
  logic [DEPTH_W-1:0] depth_inc;
  logic               a_ok, b_ok, bad;
  logic [NODE_W-1:0]  res_node;

  lca_ram #(.WIDTH(ENTRY_W), .DEPTH(ANC_DEPTH)) u_anc_ram (
    .clk   (clk),
    .we    (anc_we),
    .waddr (anc_waddr),
    .wdata (anc_wdata),
    .raddr (anc_raddr),
    .rdata (anc_rdata)
  );

  lca_ram #(.WIDTH(DEPTH_W), .DEPTH(NODES)) u_dep_ram (
    .clk   (clk),
    .we    (cmd.op == OP_LD_WR0),
    .waddr (dep_waddr),
    .wdata (dep_wdata),
    .raddr (dep_raddr),
    .rdata (dep_rdata)
  );

  // the root row and depth read as zero, it is never written
  assign anc_q = anc_zero_r ? '0 : anc_rdata;
  assign dep_q = dep_zero_r ? '0 : dep_rdata;

  assign b_entry     = {1'b0, b_r} + ENTRY_W'(1);
  assign ld_val      = (e_r == '0) ? '0 : anc_q;
  assign parent_node = NODE_W'(anc_q - ENTRY_W'(1));
  assign depth_inc   = (dep_q == DEPTH_SAT) ? DEPTH_SAT : dep_q + DEPTH_W'(1);

  // ancestor read address select
  always_comb begin
    rd_node = u_r;
    rd_lvl  = lvl_r;
    case (cmd.op)
      OP_LD_RD: begin
        rd_node = NODE_W'(e_r - ENTRY_W'(1));
        rd_lvl  = lvl_r - LVL_W'(1);
      end
      OP_J_RV:  rd_node = v_r;
      OP_P_RD:  rd_lvl  = '0;
      default:  rd_node = u_r;
    endcase
  end

  assign rd_prod   = 32'(rd_node) * 32'(LEVELS) + 32'(rd_lvl);
  assign anc_raddr = rd_prod[AAW-1:0];

  // ancestor write: row of the loaded child
  assign wr_node   = a_r;
  assign wr_lvl    = (cmd.op == OP_LD_WR0) ? '0 : lvl_r;
  assign wr_prod   = 32'(wr_node) * 32'(LEVELS) + 32'(wr_lvl);
  assign anc_waddr = wr_prod[AAW-1:0];
  assign anc_we    = (cmd.op == OP_LD_WR0) || (cmd.op == OP_LD_WR);
  assign anc_wdata = (cmd.op == OP_LD_WR0) ? b_entry : ld_val;

  // depth read and write addresses
  assign dep_rnode = (cmd.op == OP_LP_RD || cmd.op == OP_DB_RD) ? b_r : a_r;
  assign dep_rext  = 32'(dep_rnode);
  assign dep_raddr = dep_rext[DAW-1:0];
  assign dep_wext  = 32'(a_r);
  assign dep_waddr = dep_wext[DAW-1:0];
  assign dep_wdata = depth_inc;

  // item checks
  assign a_ok = (32'(a_r) < NODES);
  assign b_ok = (32'(b_r) < NODES);
  always_comb begin
    case (kind_r)
      KIND_LOAD: bad = !a_ok || !b_ok || (b_r >= a_r);
      KIND_LCA:  bad = !a_ok || !b_ok;
      KIND_KTH:  bad = !a_ok;
      default:   bad = 1'b1;
    endcase
  end

  // status to the controller
  always_comb begin
    stat.kind      = kind_r;
    stat.bad       = bad;
    stat.k_high    = (32'(k_r) >> LEVELS) != 32'd0;
    stat.k_gt      = (k_r > dep_q);
    stat.k_bit     = ((32'(k_r) >> lvl_r) & 32'd1) != 32'd0;
    stat.lvl_last  = (32'(lvl_r) == LEVELS - 1);
    stat.lvl_zero  = (lvl_r == '0);
    stat.one_level = (LEVELS == 1);
    stat.e_zero    = (anc_q == '0);
    stat.uv_eq     = (u_r == v_r);
  end

  // item, walker and level registers
  always_ff @(posedge clk) begin
    anc_zero_r <= (rd_node == '0);
    dep_zero_r <= (dep_rnode == '0);
    case (cmd.op)
      OP_CAPTURE: begin
        kind_r <= kind_t'(in_kind);
        a_r    <= in_node_a;
        b_r    <= in_node_b;
        k_r    <= in_distance;
      end
      OP_LD_WR0: begin
        e_r   <= b_entry;
        lvl_r <= LVL_W'(1);
      end
      OP_LD_WR: begin
        e_r   <= ld_val;
        lvl_r <= lvl_r + LVL_W'(1);
      end
      OP_KD_RD: begin
        u_r   <= a_r;
        lvl_r <= '0;
      end
      OP_DB_RD:   da_r <= dep_q;
      OP_LEVEL: begin
        // deeper node climbs by the depth gap
        lvl_r <= '0;
        if (da_r < dep_q) begin
          u_r <= b_r;
          v_r <= a_r;
          k_r <= NODE_W'(dep_q - da_r);
        end else begin
          u_r <= a_r;
          v_r <= b_r;
          k_r <= NODE_W'(da_r - dep_q);
        end
      end
      OP_CL_SKIP: lvl_r <= lvl_r + LVL_W'(1);
      OP_CL_STEP: begin
        u_r   <= parent_node;
        lvl_r <= lvl_r + LVL_W'(1);
      end
      OP_J_INIT:  lvl_r <= LVL_W'(LEVELS - 1);
      OP_J_RV:    e_r <= anc_q;
      OP_J_CMP: begin
        // jump both while their ancestors differ
        if (e_r != anc_q && e_r != '0 && anc_q != '0) begin
          u_r <= NODE_W'(e_r - ENTRY_W'(1));
          v_r <= parent_node;
        end
        lvl_r <= lvl_r - LVL_W'(1);
      end
      default: ;
    endcase
  end

  // answer select
  always_comb begin
    case (cmd.res)
      RES_U:      res_node = u_r;
      RES_PARENT: res_node = parent_node;
      default:    res_node = b_r;
    endcase
  end

  // result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.done;
    end
    if (cmd.done) begin
      out_status_r <= cmd.code;
      out_answer_r <= (cmd.code == STAT_OK) ? res_node : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_answer_node = out_answer_r;
  assign out_status      = out_status_r;

endmodule

// ===== design/tree_lca_binary_lifting_core.sv =====
// ----------------------------------------------------------------------------
// tree_lca_binary_lifting_core
// Rooted-tree engine (root is node 0) answering k-th ancestor and lowest
// common ancestor queries from a binary-lifting ancestor table.
// ----------------------------------------------------------------------------
// Usage:
//   An item (kind, node_a, node_b, distance) is taken when start is high and
//   busy is low. Each item gives exactly one result beat: out_valid is high
//   for one cycle with out_answer_node and out_status; the receiver cannot
//   stall and must take it in that cycle.
//   Work per item kind, with L = LEVELS:
//     load                  : writes the L entries of the child's row
//     k-th ancestor query   : walks up to L levels, reading only on set bits
//     common ancestor query : leveling climb, then a read of u, a read of v
//                             and a compare per jump level
//     bad item              : rejected at the check
//   One item is in flight at a time; the single read port of the ancestor
//   memory sets the pace of every walk. A new item may be started in the
//   cycle its predecessor's result beat is shown.
//   Reset clears the controller and the result strobe only; table contents
//   are undefined until loaded. Node 0 needs no load and reads as the root.
// ----------------------------------------------------------------------------
module tree_lca_binary_lifting_core
  import lca_pkg::*;
#(
  parameter int NODES  = 1024,
  parameter int LEVELS = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_kind,
  input  logic [NODE_W-1:0] in_node_a,
  input  logic [NODE_W-1:0] in_node_b,
  input  logic [NODE_W-1:0] in_distance,
  output logic              out_valid,
  output logic [NODE_W-1:0] out_answer_node,
  output logic [1:0]        out_status
);

  cmd_t     cmd;
  dp_stat_t stat;

  lca_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  lca_dpath #(.NODES(NODES), .LEVELS(LEVELS)) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_kind         (in_kind),
    .in_node_a       (in_node_a),
    .in_node_b       (in_node_b),
    .in_distance     (in_distance),
    .out_valid       (out_valid),
    .out_answer_node (out_answer_node),
    .out_status      (out_status)
  );

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for tree_lca_binary_lifting_core. A directed table
// covers the root, the extremes, bad loads, the unused kind and reloads, then
// random loads grow deep chains and branches that are queried at random.
// Every result beat is checked against an in-bench tree predictor or a hand-typed answer.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lca_pkg::*;

  localparam int NODE_CNT     = 1024;
  localparam int LEVEL_CNT    = 10;
  localparam int RANDOM_ITEMS = 400;
  localparam int DRAIN_CYCLES = 64;
  localparam int STALL_LIMIT  = 2000;
  localparam int DIR_CNT      = 24;

  // one input item, with an optional hand-typed answer
  typedef struct packed {
    kind_t             kind;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    logic [NODE_W-1:0] hops;
    logic              fixed;
    logic [NODE_W-1:0] ans;
    status_t           st;
  } tree_op_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    status_t           st;
  } answer_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [1:0]        in_kind;
  logic [NODE_W-1:0] in_node_a;
  logic [NODE_W-1:0] in_node_b;
  logic [NODE_W-1:0] in_distance;
  logic              out_valid;
  logic [NODE_W-1:0] out_answer_node;
  logic [1:0]        out_status;

  // predictor state: ancestor rows hold node+1, zero means none
  logic [ENTRY_W-1:0] lift_tab [0:NODE_CNT-1][0:LEVEL_CNT-1];
  logic [DEPTH_W-1:0] depth_tab [0:NODE_CNT-1];
  bit                 known [0:NODE_CNT-1];
  int                 known_q[$];
  int                 chain_tip;

  answer_t answer_q[$];
  int      fault_cnt;
  int      stall_cnt;

  // directed items: root, extremes, bad loads, reload, unused kind
  tree_op_t dir_ops [DIR_CNT] = '{
    '{KIND_KTH,  10'd0,    10'd0,    10'd0,    1'b1, 10'd0, STAT_OK},
    '{KIND_KTH,  10'd0,    10'd0,    10'd1,    1'b1, 10'd0, STAT_PAST_ROOT},
    '{KIND_LCA,  10'd0,    10'd0,    10'd0,    1'b1, 10'd0, STAT_OK},
    '{KIND_BAD,  10'd1023, 10'd1023, 10'd1023, 1'b1, 10'd0, STAT_BAD},
    '{KIND_LOAD, 10'd0,    10'd0,    10'd0,    1'b1, 10'd0, STAT_BAD},
    '{KIND_LOAD, 10'd5,    10'd5,    10'd0,    1'b1, 10'd0, STAT_BAD},
    '{KIND_LOAD, 10'd5,    10'd1023, 10'd0,    1'b1, 10'd0, STAT_BAD},
    '{KIND_LOAD, 10'd1023, 10'd0,    10'd1023, 1'b1, 10'd0, STAT_OK},
    '{KIND_LOAD, 10'd1,    10'd0,    10'd0,    1'b1, 10'd0, STAT_OK},
    '{KIND_LOAD, 10'd2,    10'd1,    10'd0,    1'b1, 10'd1, STAT_OK},
    '{KIND_LOAD, 10'd3,    10'd2,    10'd0,    1'b1, 10'd2, STAT_OK},
    '{KIND_LOAD, 10'd4,    10'd1,    10'd0,    1'b1, 10'd1, STAT_OK},
    '{KIND_LOAD, 10'd1022, 10'd3,    10'd0,    1'b1, 10'd3, STAT_OK},
    '{KIND_KTH,  10'd1022, 10'd1023, 10'd4,    1'b0, 10'd0, STAT_OK},
    '{KIND_KTH,  10'd1022, 10'd0,    10'd5,    1'b0, 10'd0, STAT_OK},
    '{KIND_KTH,  10'd1022, 10'd0,    10'd1023, 1'b0, 10'd0, STAT_OK},
    '{KIND_LCA,  10'd1022, 10'd4,    10'd0,    1'b0, 10'd0, STAT_OK},
    '{KIND_LCA,  10'd1022, 10'd1023, 10'd0,    1'b0, 10'd0, STAT_OK},
    '{KIND_LCA,  10'd3,    10'd1022, 10'd0,    1'b0, 10'd0, STAT_OK},
    '{KIND_LOAD, 10'd2,    10'd0,    10'd0,    1'b1, 10'd0, STAT_OK},
    '{KIND_KTH,  10'd3,    10'd0,    10'd3,    1'b0, 10'd0, STAT_OK},
    '{KIND_LCA,  10'd3,    10'd2,    10'd0,    1'b0, 10'd0, STAT_OK},
    '{KIND_KTH,  10'd1023, 10'd0,    10'd0,    1'b0, 10'd0, STAT_OK},
    '{KIND_BAD,  10'd0,    10'd0,    10'd0,    1'b1, 10'd0, STAT_BAD}
  };

  tree_lca_binary_lifting_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_node_a       (in_node_a),
    .in_node_b       (in_node_b),
    .in_distance     (in_distance),
    .out_valid       (out_valid),
    .out_answer_node (out_answer_node),
    .out_status      (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // climb k levels by the set bits of k; fails on a missing ancestor
  function automatic bit climb_up(input int x, input int k, output int r);
    int i;
    int e;
    r = x;
    if ((k >> LEVEL_CNT) != 0) return 1'b0;
    for (i = 0; i < LEVEL_CNT; i++) begin
      if ((k >> i) & 1) begin
        e = int'(lift_tab[r][i]);
        if (e == 0) return 1'b0;
        r = e - 1;
      end
    end
    return 1'b1;
  endfunction

  // expected answer for one item; loads update the tree
  function automatic void tree_predict(input kind_t kind, input int a, input int b,
                                       input int k, output int ans, output status_t st);
    int u;
    int v;
    int t;
    int i;
    int d;
    int prev;
    int eu;
    int ev;
    ans = 0;
    st  = STAT_BAD;
    case (kind)
      KIND_LOAD: begin
        if (b < a && a < NODE_CNT) begin
          d = int'(depth_tab[b]) + 1;
          if (d > int'(DEPTH_SAT)) d = int'(DEPTH_SAT);
          depth_tab[a] = d[DEPTH_W-1:0];
          lift_tab[a][0] = ENTRY_W'(b + 1);
          for (i = 1; i < LEVEL_CNT; i++) begin
            prev = int'(lift_tab[a][i-1]);
            lift_tab[a][i] = (prev == 0) ? '0 : lift_tab[prev-1][i-1];
          end
          if (!known[a]) begin
            known[a] = 1'b1;
            known_q  = {known_q, a};
          end
          ans = b;
          st  = STAT_OK;
        end
      end
      KIND_LCA: begin
        u = a;
        v = b;
        if (depth_tab[u] < depth_tab[v]) begin
          t = u;
          u = v;
          v = t;
        end
        if (!climb_up(u, int'(depth_tab[u]) - int'(depth_tab[v]), t)) begin
          st = STAT_PAST_ROOT;
        end else if (t == v) begin
          ans = t;
          st  = STAT_OK;
        end else begin
          u = t;
          // jump both while their ancestors differ, top power first
          for (i = LEVEL_CNT - 1; i >= 0; i--) begin
            eu = int'(lift_tab[u][i]);
            ev = int'(lift_tab[v][i]);
            if (eu != ev && eu != 0 && ev != 0) begin
              u = eu - 1;
              v = ev - 1;
            end
          end
          t = int'(lift_tab[u][0]);
          if (t == 0) begin
            st = STAT_PAST_ROOT;
          end else begin
            ans = t - 1;
            st  = STAT_OK;
          end
        end
      end
      KIND_KTH: begin
        if (k > int'(depth_tab[a]) || !climb_up(a, k, t)) begin
          st = STAT_PAST_ROOT;
        end else begin
          ans = t;
          st  = STAT_OK;
        end
      end
      default: st = STAT_BAD;
    endcase
    if (st != STAT_OK) ans = 0;
  endfunction

  function automatic int any_known();
    return known_q[$urandom_range(0, known_q.size() - 1)];
  endfunction

  // random item: mostly legal loads and queries on loaded nodes
  task automatic gen_random(output tree_op_t op);
    int sel;
    int pick;
    int c;
    int p;
    int r;
    op       = '0;
    op.kind  = KIND_LOAD;
    op.a     = NODE_W'($urandom_range(0, NODE_CNT - 1));
    op.b     = NODE_W'($urandom_range(0, NODE_CNT - 1));
    op.hops  = NODE_W'($urandom_range(0, NODE_CNT - 1));
    sel      = int'($urandom_range(0, 99));
    if (sel < 30) begin
      // extend a deep chain
      if (chain_tip > NODE_CNT - 4) begin
        chain_tip = any_known();
        if (chain_tip > NODE_CNT - 4) chain_tip = 0;
      end
      c = chain_tip + int'($urandom_range(1, 3));
      op.a = NODE_W'(c);
      op.b = NODE_W'(chain_tip);
      chain_tip = c;
    end else if (sel < 40) begin
      // branch or reload under a deep loaded node below the child
      c = int'($urandom_range(1, NODE_CNT - 1));
      p = 0;
      repeat (8) begin
        pick = any_known();
        if (pick < c && depth_tab[pick] >= depth_tab[p]) p = pick;
      end
      op.a = NODE_W'(c);
      op.b = NODE_W'(p);
    end else if (sel < 44) begin
      // bad load: parent not below child
      c = int'($urandom_range(0, NODE_CNT - 1));
      op.a = NODE_W'(c);
      op.b = NODE_W'($urandom_range(c, NODE_CNT - 1));
    end else if (sel < 70) begin
      op.kind = KIND_LCA;
      op.a = NODE_W'(any_known());
      r = int'($urandom_range(0, 99));
      if (r < 40) begin
        op.b = NODE_W'(any_known());
      end else if (r < 80) begin
        if (!climb_up(int'(op.a), int'($urandom_range(0, depth_tab[op.a])), pick))
          pick = 0;
        op.b = NODE_W'(pick);
      end else begin
        op.b = op.a;
      end
      if ($urandom_range(0, 1)) begin
        pick = int'(op.a);
        op.a = op.b;
        op.b = NODE_W'(pick);
      end
    end else if (sel < 95) begin
      op.kind = KIND_KTH;
      op.a = NODE_W'(any_known());
      r = int'($urandom_range(0, 99));
      if (r < 70) op.hops = NODE_W'($urandom_range(0, depth_tab[op.a]));
      else if (r < 90 && depth_tab[op.a] < NODE_CNT - 4)
        op.hops = NODE_W'(depth_tab[op.a] + $urandom_range(0, 3));
    end else begin
      op.kind = KIND_BAD;
    end
  endtask

  // hold the item until accepted, then log its expected answer
  task automatic apply_op(input tree_op_t op);
    int      got;
    status_t st;
    answer_t want;
    @(negedge clk);
    start       <= 1'b1;
    in_kind     <= op.kind;
    in_node_a   <= op.a;
    in_node_b   <= op.b;
    in_distance <= op.hops;
    do @(posedge clk); while (busy !== 1'b0);
    tree_predict(op.kind, int'(op.a), int'(op.b), int'(op.hops), got, st);
    if (op.fixed) begin
      want.node = op.ans;
      want.st   = op.st;
    end else begin
      want.node = got[NODE_W-1:0];
      want.st   = st;
    end
    answer_q = {answer_q, want};
  endtask

  // one cycle with start low and junk on the fields
  task automatic idle_cycle();
    @(negedge clk);
    start       <= 1'b0;
    in_kind     <= 2'($urandom_range(0, 3));
    in_node_a   <= NODE_W'($urandom_range(0, NODE_CNT - 1));
    in_node_b   <= NODE_W'($urandom_range(0, NODE_CNT - 1));
    in_distance <= NODE_W'($urandom_range(0, NODE_CNT - 1));
  endtask

  // stimulus
  initial begin : stimulus
    int       n;
    int       i;
    int       j;
    tree_op_t op;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_kind     = KIND_LOAD;
    in_node_a   = '0;
    in_node_b   = '0;
    in_distance = '0;
    fault_cnt   = 0;
    chain_tip   = 0;
    for (i = 0; i < NODE_CNT; i++) begin
      depth_tab[i] = '0;
      known[i]     = 1'b0;
      for (j = 0; j < LEVEL_CNT; j++) lift_tab[i][j] = '0;
    end
    known[0] = 1'b1;
    known_q  = {known_q, 0};

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (n = 0; n < DIR_CNT; n++) begin
      while ($urandom_range(0, 99) < 9) idle_cycle();
      apply_op(dir_ops[n]);
    end

    // random part, with a quiet stretch of back-to-back items
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n < 150 || n >= 250)
        while ($urandom_range(0, 99) < 9) idle_cycle();
      gen_random(op);
      apply_op(op);
    end
    idle_cycle();

    while (answer_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // result beat check
  always @(posedge clk) begin : check_results
    answer_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (answer_q.size() == 0) begin
        if (fault_cnt < 10)
          $display("unexpected result beat: node %0d status %0d",
                   out_answer_node, out_status);
        fault_cnt++;
      end else begin
        want = answer_q.pop_front();
        if (out_answer_node !== want.node || out_status !== want.st) begin
          if (fault_cnt < 10)
            $display("mismatch: expected node %0d status %0d, got node %0d status %0d",
                     want.node, want.st, out_answer_node, out_status);
          fault_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no beat in either direction
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) stall_cnt = 0;
    else stall_cnt = stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial stall_cnt = 0;

endmodule
